// ===== hdl/tah_pkg.sv =====
package tah_pkg;

  localparam int BUCKET_COUNT = 64;
  localparam int MAX_ENTRIES = 256;
  localparam int MAX_FLUSH   = 16;

  localparam int BKT_W   = $clog2(BUCKET_COUNT);
  localparam int SLOT_W  = $clog2(MAX_ENTRIES);
  localparam int LINK_W  = SLOT_W + 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int LIM_W   = 5;
  localparam int KEY_W   = 64;
  localparam int SPAN_W  = 16;
  localparam int TICK_W  = 32;
  localparam int TLIM_W  = 9;
  localparam int OSLOT_W = 8;
  localparam int KEY_BYTES = 8;

  localparam int SCAN_LANES = 16;
  localparam int LANE_W     = $clog2(SCAN_LANES);
  localparam int CHUNK_W    = SLOT_W - LANE_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_ENTRIES);
  localparam logic [KEY_W-1:0]  FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [KEY_W-1:0]  FNV_PRIME = 64'h00000100000001b3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_TICK   = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_FIND   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_DONE        = 3'd0,
    ST_TRACE_DROP  = 3'd1,
    ST_SPAN_DROP   = 3'd2,
    ST_FOUND       = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_FLUSHED     = 3'd5,
    ST_FLUSH_DONE  = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_START,
    B_HEAD,
    B_ENT,
    B_MISS,
    B_SCAN,
    B_CREATE,
    B_FDONE
  } back_state_e;

  typedef struct packed {
    opcode_e            op;
    logic [KEY_W-1:0]   key;
    logic               root;
    logic               samp;
    logic [LIM_W-1:0]   lim;
    logic [TICK_W-1:0]  tmo;
    logic [BKT_W-1:0]   bkt;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [KEY_W-1:0]    key;
    logic [OSLOT_W-1:0]  slot;
    logic [SPAN_W-1:0]   spans;
    logic                root;
    logic                samp;
    logic [CNT_W-1:0]    active;
    logic [31:0]         tlost;
    logic [31:0]         slost;
    logic                last;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SPAN_W-1:0]  spans;
    logic               root;
    logic               samp;
    logic [TICK_W-1:0]  stamp;
  } rec_t;

  // The low bits of FNV-1a depend only on the low bits of every step, so the
  // bucket is found on a hash as narrow as the bucket index.
  function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
    logic [BKT_W-1:0] h;
    h = FNV_BASIS[BKT_W-1:0];
    for (int i = 0; i < KEY_BYTES; i++) begin
      h = h ^ BKT_W'(key[8*i +: 8]);
      h = BKT_W'(h * FNV_PRIME[BKT_W-1:0]);
    end
    return h;
  endfunction

endpackage

// ===== hdl/tah_front.sv =====
module tah_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tah_pkg::opcode_e     op_i,
  input  logic [63:0]          key_i,
  input  logic                 root_i,
  input  logic                 samp_i,
  input  logic [4:0]           lim_i,
  input  logic [31:0]          tmo_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output tah_pkg::req_t        push_req_o
);

  logic          vld_q, vld_d;
  tah_pkg::req_t req_q, req_d;
  logic          take;

  assign in_ready_o = !vld_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    req_d      = req_q;
    vld_d      = vld_q && !push_ready_i;
    if (take) begin
      vld_d      = 1'b1;
      req_d.op   = op_i;
      req_d.key  = key_i;
      req_d.root = root_i;
      req_d.samp = samp_i;
      req_d.lim  = (lim_i > tah_pkg::LIM_W'(tah_pkg::MAX_FLUSH)) ?
                   tah_pkg::LIM_W'(tah_pkg::MAX_FLUSH) : lim_i;
      req_d.tmo  = tmo_i;
      req_d.bkt  = tah_pkg::bucket_of(key_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign push_valid_o = vld_q;
  assign push_req_o   = req_q;

endmodule

// ===== hdl/tah_queue.sv =====
module tah_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           push_ready_o,
  input  tah_pkg::req_t  push_req_i,
  input  logic           pop_i,
  output logic           pop_valid_o,
  output tah_pkg::req_t  pop_req_o
);

  tah_pkg::req_t                   mem_q [tah_pkg::QUEUE_DEPTH];
  logic [tah_pkg::QPTR_W-1:0]      wr_q, rd_q;
  logic [tah_pkg::QCNT_W-1:0]      cnt_q;
  logic                            do_push, do_pop;

  assign push_ready_o = cnt_q != tah_pkg::QCNT_W'(tah_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_req_o    = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_req_i;
    end
  end

endmodule

// ===== hdl/tah_back.sv =====
module tah_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  tah_pkg::req_t       req_i,
  output logic                req_pop_o,
  input  logic [8:0]          trace_limit_i,
  input  logic [15:0]         span_limit_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tah_pkg::res_t       out_res_o
);

  localparam int NB = tah_pkg::BUCKET_COUNT;
  localparam int NE = tah_pkg::MAX_ENTRIES;
  localparam int SW = tah_pkg::SLOT_W;
  localparam int LW = tah_pkg::LINK_W;
  localparam int BW = tah_pkg::BKT_W;
  localparam int CW = tah_pkg::CNT_W;

  tah_pkg::back_state_e state_q, state_d;
  tah_pkg::req_t        cur_q, cur_d;
  logic [BW-1:0]        b_q, b_d;
  logic [LW-1:0]        e_q, e_d, prev_q, prev_d, hd_q, hd_d;
  logic [tah_pkg::LIM_W-1:0]   done_q, done_d;
  logic [tah_pkg::CHUNK_W-1:0] chunk_q, chunk_d;
  logic [SW-1:0]        f_q, f_d;
  logic [31:0]          now_q, now_d, tlost_q, tlost_d, slost_q, slost_d;
  logic [CW-1:0]        active_q, active_d;
  logic [NE-1:0]        ev_q;
  logic [NB-1:0]        hv_q;
  logic                 out_vld_q;
  tah_pkg::res_t        out_q, res;
  logic                 load;

  logic [LW-1:0]        head_mem [NB];
  tah_pkg::rec_t        rec_mem  [NE];
  logic [LW-1:0]        link_mem [NE];
  logic [LW-1:0]        head_rd_q, link_rd_q;
  tah_pkg::rec_t        rec_rd_q;

  logic                 head_we, rec_we, link_we, ev_set, ev_clr, hv_set;
  logic [LW-1:0]        head_wd, link_wd;
  logic [SW-1:0]        rec_wa, link_wa, ev_idx;
  tah_pkg::rec_t        rec_wd;

  logic                 out_free, hit, idle, limit_hit, full, free_any, is_flush;
  logic [LW-1:0]        head_link, nx;
  logic [tah_pkg::SCAN_LANES-1:0] grp;
  logic [tah_pkg::LANE_W-1:0]     lane;
  logic [tah_pkg::SPAN_W-1:0]     spans_inc;

  assign out_free  = !out_vld_q || out_ready_i;
  assign head_link = hv_q[b_q] ? head_rd_q : tah_pkg::NULL_LINK;
  assign nx        = link_rd_q;
  assign hit       = ev_q[e_q[SW-1:0]] && (rec_rd_q.key == cur_q.key);
  assign idle      = (now_q - rec_rd_q.stamp) >= cur_q.tmo;
  assign limit_hit = (span_limit_i != '0) && (rec_rd_q.spans >= span_limit_i);
  assign full      = ((trace_limit_i != '0) && (active_q >= trace_limit_i)) ||
                     (active_q >= CW'(NE));
  assign is_flush  = cur_q.op == tah_pkg::OP_FLUSH;
  assign spans_inc = (&rec_rd_q.spans) ? rec_rd_q.spans : rec_rd_q.spans + 1'b1;
  assign grp       = ev_q[chunk_q * tah_pkg::SCAN_LANES +: tah_pkg::SCAN_LANES];
  assign free_any  = ~&grp;

  always_comb begin
    lane = '0;
    for (int i = tah_pkg::SCAN_LANES - 1; i >= 0; i--) begin
      if (!grp[i]) begin
        lane = tah_pkg::LANE_W'(i);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    b_d      = b_q;
    e_d      = e_q;
    prev_d   = prev_q;
    hd_d     = hd_q;
    done_d   = done_q;
    chunk_d  = chunk_q;
    f_d      = f_q;
    now_d    = now_q;
    active_d = active_q;
    tlost_d  = tlost_q;
    slost_d  = slost_q;
    req_pop_o = 1'b0;
    head_we  = 1'b0;
    head_wd  = '0;
    rec_we   = 1'b0;
    rec_wa   = e_q[SW-1:0];
    rec_wd   = rec_rd_q;
    link_we  = 1'b0;
    link_wa  = prev_q[SW-1:0];
    link_wd  = nx;
    ev_set   = 1'b0;
    ev_clr   = 1'b0;
    ev_idx   = e_q[SW-1:0];
    hv_set   = 1'b0;
    load     = 1'b0;
    res      = '0;
    res.last = 1'b1;

    unique case (state_q)
      tah_pkg::B_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          cur_d     = req_i;
          b_d       = req_i.bkt;
          state_d   = tah_pkg::B_START;
        end
      end
      tah_pkg::B_START: begin
        case (cur_q.op)
          tah_pkg::OP_TICK: begin
            if (out_free) begin
              now_d      = now_q + 1'b1;
              load       = 1'b1;
              res.status = tah_pkg::ST_DONE;
              state_d    = tah_pkg::B_IDLE;
            end
          end
          tah_pkg::OP_FLUSH: begin
            done_d = '0;
            if (cur_q.lim == '0) begin
              state_d = tah_pkg::B_FDONE;
            end else begin
              b_d     = '0;
              state_d = tah_pkg::B_HEAD;
            end
          end
          default: begin
            state_d = tah_pkg::B_HEAD;
          end
        endcase
      end
      tah_pkg::B_HEAD: begin
        if (is_flush) begin
          prev_d = tah_pkg::NULL_LINK;
          if (head_link == tah_pkg::NULL_LINK) begin
            if (b_q == BW'(NB - 1)) begin
              state_d = tah_pkg::B_FDONE;
            end else begin
              b_d = b_q + 1'b1;
            end
          end else begin
            e_d     = head_link;
            state_d = tah_pkg::B_ENT;
          end
        end else begin
          hd_d = head_link;
          if (head_link == tah_pkg::NULL_LINK) begin
            state_d = tah_pkg::B_MISS;
          end else begin
            e_d     = head_link;
            state_d = tah_pkg::B_ENT;
          end
        end
      end
      tah_pkg::B_ENT: begin
        if (is_flush) begin
          if (idle) begin
            if (out_free) begin
              if (prev_q == tah_pkg::NULL_LINK) begin
                head_we = 1'b1;
                head_wd = nx;
              end else begin
                link_we = 1'b1;
              end
              ev_clr     = 1'b1;
              active_d   = (active_q != '0) ? active_q - 1'b1 : active_q;
              done_d     = done_q + 1'b1;
              load       = 1'b1;
              res.status = tah_pkg::ST_FLUSHED;
              res.key    = rec_rd_q.key;
              res.slot   = tah_pkg::OSLOT_W'(e_q);
              res.spans  = rec_rd_q.spans;
              res.root   = rec_rd_q.root;
              res.samp   = rec_rd_q.samp;
              res.last   = 1'b0;
              if (done_d == cur_q.lim) begin
                state_d = tah_pkg::B_FDONE;
              end else if (nx == tah_pkg::NULL_LINK) begin
                if (b_q == BW'(NB - 1)) begin
                  state_d = tah_pkg::B_FDONE;
                end else begin
                  b_d     = b_q + 1'b1;
                  state_d = tah_pkg::B_HEAD;
                end
              end else begin
                e_d = nx;
              end
            end
          end else begin
            prev_d = e_q;
            if (nx == tah_pkg::NULL_LINK) begin
              if (b_q == BW'(NB - 1)) begin
                state_d = tah_pkg::B_FDONE;
              end else begin
                b_d     = b_q + 1'b1;
                state_d = tah_pkg::B_HEAD;
              end
            end else begin
              e_d = nx;
            end
          end
        end else if (hit) begin
          if (out_free) begin
            load      = 1'b1;
            res.key   = cur_q.key;
            res.slot  = tah_pkg::OSLOT_W'(e_q);
            res.spans = rec_rd_q.spans;
            res.root  = rec_rd_q.root;
            res.samp  = rec_rd_q.samp;
            state_d   = tah_pkg::B_IDLE;
            if (cur_q.op == tah_pkg::OP_FIND) begin
              res.status = tah_pkg::ST_FOUND;
            end else if (limit_hit) begin
              slost_d    = (&slost_q) ? slost_q : slost_q + 1'b1;
              res.status = tah_pkg::ST_SPAN_DROP;
            end else begin
              rec_we       = 1'b1;
              rec_wd.spans = spans_inc;
              rec_wd.root  = rec_rd_q.root | cur_q.root;
              rec_wd.samp  = (spans_inc == tah_pkg::SPAN_W'(1)) ? cur_q.samp
                                                                 : rec_rd_q.samp;
              rec_wd.stamp = now_q;
              res.status   = tah_pkg::ST_DONE;
              res.spans    = rec_wd.spans;
              res.root     = rec_wd.root;
              res.samp     = rec_wd.samp;
            end
          end
        end else if (nx == tah_pkg::NULL_LINK) begin
          state_d = tah_pkg::B_MISS;
        end else begin
          e_d = nx;
        end
      end
      tah_pkg::B_MISS: begin
        if (cur_q.op == tah_pkg::OP_FIND || full) begin
          if (out_free) begin
            load    = 1'b1;
            res.key = cur_q.key;
            state_d = tah_pkg::B_IDLE;
            if (cur_q.op == tah_pkg::OP_FIND) begin
              res.status = tah_pkg::ST_NOT_FOUND;
            end else begin
              tlost_d    = (&tlost_q) ? tlost_q : tlost_q + 1'b1;
              res.status = tah_pkg::ST_TRACE_DROP;
            end
          end
        end else begin
          chunk_d = '0;
          state_d = tah_pkg::B_SCAN;
        end
      end
      tah_pkg::B_SCAN: begin
        if (free_any) begin
          f_d     = {chunk_q, lane};
          state_d = tah_pkg::B_CREATE;
        end else begin
          chunk_d = chunk_q + 1'b1;
        end
      end
      tah_pkg::B_CREATE: begin
        if (out_free) begin
          rec_we       = 1'b1;
          rec_wa       = f_q;
          rec_wd.key   = cur_q.key;
          rec_wd.spans = tah_pkg::SPAN_W'(1);
          rec_wd.root  = cur_q.root;
          rec_wd.samp  = cur_q.samp;
          rec_wd.stamp = now_q;
          link_we      = 1'b1;
          link_wa      = f_q;
          link_wd      = hd_q;
          head_we      = 1'b1;
          head_wd      = {1'b0, f_q};
          hv_set       = 1'b1;
          ev_set       = 1'b1;
          ev_idx       = f_q;
          active_d     = active_q + 1'b1;
          load         = 1'b1;
          res.status   = tah_pkg::ST_DONE;
          res.key      = cur_q.key;
          res.slot     = tah_pkg::OSLOT_W'(f_q);
          res.spans    = tah_pkg::SPAN_W'(1);
          res.root     = cur_q.root;
          res.samp     = cur_q.samp;
          state_d      = tah_pkg::B_IDLE;
        end
      end
      tah_pkg::B_FDONE: begin
        if (out_free) begin
          load       = 1'b1;
          res.status = tah_pkg::ST_FLUSH_DONE;
          state_d    = tah_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = tah_pkg::B_IDLE;
      end
    endcase

    res.active = active_d;
    res.tlost  = tlost_d;
    res.slost  = slost_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tah_pkg::B_IDLE;
      now_q     <= '0;
      active_q  <= '0;
      tlost_q   <= '0;
      slost_q   <= '0;
      ev_q      <= '0;
      hv_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      now_q    <= now_d;
      active_q <= active_d;
      tlost_q  <= tlost_d;
      slost_q  <= slost_d;
      if (ev_set) begin
        ev_q[ev_idx] <= 1'b1;
      end else if (ev_clr) begin
        ev_q[ev_idx] <= 1'b0;
      end
      if (hv_set) begin
        hv_q[b_q] <= 1'b1;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    b_q     <= b_d;
    e_q     <= e_d;
    prev_q  <= prev_d;
    hd_q    <= hd_d;
    done_q  <= done_d;
    chunk_q <= chunk_d;
    f_q     <= f_d;
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[b_q] <= head_wd;
    end
    head_rd_q <= head_mem[b_d];
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
    rec_rd_q <= rec_mem[e_d[SW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_q <= link_mem[e_d[SW-1:0]];
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule

// ===== hdl/trace_assembly_hash_table_unit.sv =====
// Table of active traces keyed by a 64-bit id, hashed with FNV-1a into 64
// chained buckets. A request passes a classifying stage that computes the
// bucket and a two-deep queue, and is then carried out alone by a sequencer
// over memories that each have one read and one write port. A find or an
// insert walks the chain of its bucket; an insert that creates a trace then
// searches the free slots in groups of 16. A flush walks the buckets in turn,
// at most 64, and the entries of each. Results wait in an output register, so
// the next request is taken while the last result is still pending; the
// sequencer stalls to write a result while that register is full.
// Configuration must only be written while the block is idle.
module trace_assembly_hash_table_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // trace_key, is_root, sampled_flag, flush_limit, flush_timeout, zero pad
  input  logic [103:0]  s_axis_tdata,
  // opcode
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // result_key, slot, span_total, root_seen, trace_sampled, active_total,
  // traces_lost, spans_lost, zero pad
  output logic [167:0]  m_axis_tdata,
  // status
  output logic [2:0]    m_axis_tuser,
  output logic          m_axis_tlast,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [8:0]     trace_limit_q;
  logic [15:0]    span_limit_q;
  logic           cfg_we;
  logic           push_valid, push_ready, pop, pop_valid;
  tah_pkg::req_t  push_req, pop_req;
  tah_pkg::res_t  res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {16'd0, span_limit_q} : {23'd0, trace_limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trace_limit_q <= 9'd256;
      span_limit_q  <= 16'd1024;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        span_limit_q <= pwdata[15:0];
      end else begin
        trace_limit_q <= pwdata[8:0];
      end
    end
  end

  tah_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (tah_pkg::opcode_e'(s_axis_tuser)),
    .key_i        (s_axis_tdata[63:0]),
    .root_i       (s_axis_tdata[64]),
    .samp_i       (s_axis_tdata[65]),
    .lim_i        (s_axis_tdata[70:66]),
    .tmo_i        (s_axis_tdata[102:71]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_req_o   (push_req)
  );

  tah_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_ready_o (push_ready),
    .push_req_i   (push_req),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_req_o    (pop_req)
  );

  tah_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (pop_valid),
    .req_i         (pop_req),
    .req_pop_o     (pop),
    .trace_limit_i (trace_limit_q),
    .span_limit_i  (span_limit_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_res_o     (res)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {5'd0, res.slost, res.tlost, res.active, res.samp, res.root,
                         res.spans, res.slot, res.key};

`ifndef ASSERT_OFF
  a_flushed_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == tah_pkg::ST_FLUSHED) |-> !m_axis_tlast)
    else $error("flushed trace result marked as last");

  a_flush_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == tah_pkg::ST_FLUSH_DONE) |->
    (m_axis_tlast && m_axis_tdata[63:0] == 64'd0))
    else $error("flush done result malformed");

  a_active_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[98:90] <= 9'd256))
    else $error("active trace count exceeds table size");
`endif

endmodule
